>>> hdl/tx_descriptor_ring_segmenter_assert.svh
// ---------------------------------------------------------------------------
// tx descriptor ring segmenter assertion macros
// shared helpers for the concurrent checks at the end of the ring segmenter module
// ---------------------------------------------------------------------------
`ifndef TX_DESCRIPTOR_RING_SEGMENTER_ASSERT_SVH
`define TX_DESCRIPTOR_RING_SEGMENTER_ASSERT_SVH

// same-cycle implication, held off while reset is high
`define TXDRS_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off while reset is high
`define TXDRS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/txdrs_pkg.sv
// ---------------------------------------------------------------------------
// txdrs_pkg
// types and constants shared by the transmit descriptor ring segmenter
// ---------------------------------------------------------------------------
package txdrs_pkg;

   // field widths
   localparam int IDX_W       = 6;
   localparam int LEN_W       = 16;
   localparam int SEG_W       = 15;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;

   // operation codes carried on req_tuser
   localparam logic OP_SUBMIT   = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   // result status codes carried on rsp_tuser
   localparam logic [STATUS_W-1:0] RSP_PLACED     = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_QUEUE_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_EMPTY      = 2'd2;

   // answer of the shared segment unit for the current remaining length
   typedef struct packed {
      logic             fits;        // remaining bytes fit in one segment
      logic [SEG_W-1:0] seg_len;     // bytes of this segment
      logic [LEN_W-1:0] remain_next; // bytes left after this segment
   } seg_calc_type;

endpackage

>>> hdl/tx_descriptor_ring_segmenter.sv
// ---------------------------------------------------------------------------
// tx_descriptor_ring_segmenter
// transmit descriptor ring with packet segmentation and busy tracking
// ---------------------------------------------------------------------------
// Usage: req_ carries submit and completion items (req_tuser = operation).
// A submit cuts packet_length into segments of at most SEGMENT_BYTES, one ring
// slot per segment from the producer index, and gives one rsp_ item per
// segment; rsp_tlast marks the final item of the submit. If a needed slot is
// busy, or the packet needs more segments than the ring holds, one queue-full
// item is given and nothing changes. A zero length gives one empty item.
// A completion frees one slot and gives no item.
// Order: a submit is accepted, the check walk tests one slot per segment,
// then the emit walk places the segments; a refused submit goes from the check
// walk to one report item. The check and emit walks share one subtract and
// compare unit, one segment per cycle (the emit walk only while the output
// register is free), and req_tready stays low while a submit is in progress.
// Reset: every slot free, producer index zero, no item pending.
// Stall: the last result waits in the output register while the next item is
// taken; a stalled rsp_ side holds the emit walk until the register is free.
// ---------------------------------------------------------------------------
module tx_descriptor_ring_segmenter #(
   parameter int RING_DEPTH    = 64,
   parameter int SEGMENT_BYTES = 1518
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] packet_length, [21:16] done_index, [23:22] zero
   input  logic [txdrs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] operation
   input  logic                                req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [5:0] descriptor_index, [20:6] segment_length, [36:21] source_offset,
   // [37] end_of_packet, [43:38] new_tail, [47:44] zero
   output logic [txdrs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [txdrs_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast
);
   import txdrs_pkg::*;

   `include "tx_descriptor_ring_segmenter_assert.svh"

   localparam int RW = $clog2(RING_DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_EMIT   = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [RING_DEPTH-1:0]   slot_busy_ff, slot_busy_in;
   logic [IDX_W-1:0]        prod_ff, prod_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        count_ff, count_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        remain_ff, remain_in;
   logic [LEN_W-1:0]        offset_ff, offset_in;
   logic [STATUS_W-1:0]     report_ff, report_in;

   logic                    out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]     out_status_ff, out_status_in;
   logic [IDX_W-1:0]        out_desc_ff, out_desc_in;
   logic [SEG_W-1:0]        out_seg_ff, out_seg_in;
   logic [LEN_W-1:0]        out_off_ff, out_off_in;
   logic                    out_eop_ff, out_eop_in;
   logic [IDX_W-1:0]        out_tail_ff, out_tail_in;
   logic                    out_last_ff, out_last_in;

   logic                    req_accept;
   logic                    out_free;
   logic                    emit_load;
   logic [LEN_W-1:0]        req_len;
   logic [IDX_W-1:0]        req_done;
   logic [IDX_W-1:0]        idx_next;
   logic [RW-1:0]           walk_slot;
   seg_calc_type            calc;

   // request unpacking and handshake
   assign req_len    = req_tdata[LEN_W-1:0];
   assign req_done   = req_tdata[LEN_W+IDX_W-1:LEN_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign emit_load  = (state_ff == ST_EMIT) && out_free;

   // ring walk position
   assign walk_slot = idx_ff[RW-1:0];
   assign idx_next  = (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;

   // shared segment unit
   txdrs_seg_unit #(
      .SEGMENT_BYTES (SEGMENT_BYTES)
   ) u_seg_unit (
      .remain (remain_ff),
      .calc   (calc)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      slot_busy_in  = slot_busy_ff;
      prod_in       = prod_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      remain_in     = remain_ff;
      offset_in     = offset_ff;
      report_in     = report_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_desc_in   = out_desc_ff;
      out_seg_in    = out_seg_ff;
      out_off_in    = out_off_ff;
      out_eop_in    = out_eop_ff;
      out_tail_in   = out_tail_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == OP_COMPLETE) begin
                  if ({1'b0, req_done} < (IDX_W+1)'(RING_DEPTH)) begin
                     slot_busy_in[req_done[RW-1:0]] = 1'b0;
                  end
               end else if (req_len == '0) begin
                  report_in = RSP_EMPTY;
                  state_in  = ST_REPORT;
               end else begin
                  len_in    = req_len;
                  remain_in = req_len;
                  idx_in    = prod_ff;
                  count_in  = '0;
                  state_in  = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // one slot per cycle: busy, fits, or out of ring
            if (slot_busy_ff[walk_slot]) begin
               report_in = RSP_QUEUE_FULL;
               state_in  = ST_REPORT;
            end else if (calc.fits) begin
               remain_in = len_ff;
               offset_in = '0;
               idx_in    = prod_ff;
               state_in  = ST_EMIT;
            end else if (count_ff == LAST_SLOT) begin
               report_in = RSP_QUEUE_FULL;
               state_in  = ST_REPORT;
            end else begin
               remain_in = calc.remain_next;
               idx_in    = idx_next;
               count_in  = count_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            // one segment per cycle while the output register is free
            if (out_free) begin
               out_valid_in            = 1'b1;
               out_status_in           = RSP_PLACED;
               out_desc_in             = idx_ff;
               out_seg_in              = calc.seg_len;
               out_off_in              = offset_ff;
               out_eop_in              = calc.fits;
               out_tail_in             = idx_next;
               out_last_in             = calc.fits;
               slot_busy_in[walk_slot] = 1'b1;
               offset_in               = offset_ff + LEN_W'(calc.seg_len);
               remain_in               = calc.remain_next;
               idx_in                  = idx_next;
               if (calc.fits) begin
                  prod_in  = idx_next;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = report_ff;
               out_desc_in   = '0;
               out_seg_in    = '0;
               out_off_in    = '0;
               out_eop_in    = 1'b0;
               out_tail_in   = prod_ff;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_busy_ff <= '0;
         prod_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_busy_ff <= slot_busy_in;
         prod_ff      <= prod_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // walk and result payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      count_ff      <= count_in;
      len_ff        <= len_in;
      remain_ff     <= remain_in;
      offset_ff     <= offset_in;
      report_ff     <= report_in;
      out_status_ff <= out_status_in;
      out_desc_ff   <= out_desc_in;
      out_seg_ff    <= out_seg_in;
      out_off_ff    <= out_off_in;
      out_eop_ff    <= out_eop_in;
      out_tail_ff   <= out_tail_in;
      out_last_ff   <= out_last_in;
   end

   // response packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_tail_ff, out_eop_ff, out_off_ff, out_seg_ff, out_desc_ff};

   // checks
   `TXDRS_ASSERT_IMPLIES(a_refusal_is_last, clock, reset,
      rsp_tvalid && (rsp_tuser != RSP_PLACED), rsp_tlast,
      "refused submit item not marked last")
   `TXDRS_ASSERT_IMPLIES(a_prod_in_ring, clock, reset,
      1'b1, prod_ff <= LAST_SLOT,
      "producer index beyond ring")
   `TXDRS_ASSERT_NEXT(a_emit_marks_busy, clock, reset,
      emit_load, slot_busy_ff[$past(walk_slot)],
      "placed segment left its slot free")
   `TXDRS_ASSERT_IMPLIES(a_emit_slot_free, clock, reset,
      emit_load, !slot_busy_ff[walk_slot],
      "segment placed on a busy slot")

endmodule

>>> hdl/txdrs_seg_unit.sv
// ---------------------------------------------------------------------------
// txdrs_seg_unit
// shared subtract and compare unit: cuts one segment off the remaining length
// ---------------------------------------------------------------------------
module txdrs_seg_unit #(
   parameter int SEGMENT_BYTES = 1518
) (
   input  logic [txdrs_pkg::LEN_W-1:0] remain,
   output txdrs_pkg::seg_calc_type     calc
);
   import txdrs_pkg::*;

   localparam logic [LEN_W-1:0] SEG_BYTES_L = LEN_W'(SEGMENT_BYTES);

   // one compare and one subtract, reused by the check walk and the emit walk
   always_comb begin
      calc.fits        = (remain <= SEG_BYTES_L);
      calc.seg_len     = calc.fits ? remain[SEG_W-1:0] : SEG_W'(SEGMENT_BYTES);
      calc.remain_next = remain - SEG_BYTES_L;
   end

endmodule

>>> tb/tx_descriptor_ring_segmenter_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tx_descriptor_ring_segmenter_tb
// Drives submit and completion items into the ring segmenter and predicts
// every segment item from its own copy of the slot marks and producer index.
// Results are compared field by field in order of arrival. The run goes
// through three idling phases on the request and response sides.
// ---------------------------------------------------------------------------
module tx_descriptor_ring_segmenter_tb;
   import txdrs_pkg::*;

   localparam int RING_DEPTH    = 64;
   localparam int SEGMENT_BYTES = 1518;
   localparam int RANDOM_ITEMS  = 115;
   localparam int DRAIN_CYCLES  = 150;

   // expected fields of one segment item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    desc_idx;
      logic [SEG_W-1:0]    seg_len;
      logic [LEN_W-1:0]    src_offset;
      logic                eop;
      logic [IDX_W-1:0]    new_tail;
      logic                is_last;
   } segment_result_type;

   // ring predictor and segment checker
   class ring_scoreboard;
      segment_result_type segment_q[$];
      bit [RING_DEPTH-1:0] slot_free;
      logic [IDX_W-1:0] producer;
      int errors;

      function new();
         slot_free = '1;
         producer  = '0;
         errors    = 0;
      endfunction

      function logic [IDX_W-1:0] ring_step(logic [IDX_W-1:0] idx);
         return (idx == RING_DEPTH - 1) ? '0 : idx + 1'b1;
      endfunction

      // works out the segments caused by one accepted request item
      function void note_item(logic op, logic [LEN_W-1:0] len, logic [IDX_W-1:0] done_idx);
         segment_result_type res;
         int seg_count;
         bit fits;
         logic [IDX_W-1:0] idx;
         logic [IDX_W-1:0] nxt;
         logic [LEN_W-1:0] offset;
         logic [LEN_W-1:0] remain;
         logic [LEN_W-1:0] piece_len;
         res = '0;
         if (op == OP_COMPLETE) begin
            slot_free[done_idx] = 1'b1;
            return;
         end
         res.new_tail = producer;
         res.is_last  = 1'b1;
         if (len == 0) begin
            res.status = RSP_EMPTY;
            segment_q.push_back(res);
            return;
         end
         seg_count = (int'(len) + SEGMENT_BYTES - 1) / SEGMENT_BYTES;
         fits = (seg_count <= RING_DEPTH);
         // every slot the packet needs must be free
         idx = producer;
         for (int k = 0; k < seg_count && fits; k++) begin
            if (!slot_free[idx])
               fits = 1'b0;
            idx = ring_step(idx);
         end
         if (!fits) begin
            res.status = RSP_QUEUE_FULL;
            segment_q.push_back(res);
            return;
         end
         // place one segment per slot
         idx = producer;
         offset = '0;
         for (int k = 0; k < seg_count; k++) begin
            remain    = len - offset;
            piece_len = (remain > SEGMENT_BYTES) ? LEN_W'(SEGMENT_BYTES) : remain;
            nxt       = ring_step(idx);
            slot_free[idx] = 1'b0;
            res.status     = RSP_PLACED;
            res.desc_idx   = idx;
            res.seg_len    = SEG_W'(piece_len);
            res.src_offset = offset;
            res.eop        = (k == seg_count - 1);
            res.new_tail   = nxt;
            res.is_last    = res.eop;
            segment_q.push_back(res);
            offset = offset + piece_len;
            idx    = nxt;
         end
         producer = idx;
      endfunction

      // compares one accepted result item with the oldest expectation
      function void check_segment(logic [STATUS_W-1:0] status, logic [RSP_TDATA_W-1:0] data,
                                  logic tlast);
         segment_result_type want;
         if (segment_q.size() == 0) begin
            $error("unexpected result item: status %0d data %h", status, data);
            errors++;
            return;
         end
         want = segment_q.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (data[5:0] !== want.desc_idx) begin
            $error("descriptor_index: expected %0d, actual %0d", want.desc_idx, data[5:0]);
            errors++;
         end
         if (data[20:6] !== want.seg_len) begin
            $error("segment_length: expected %0d, actual %0d", want.seg_len, data[20:6]);
            errors++;
         end
         if (data[36:21] !== want.src_offset) begin
            $error("source_offset: expected %0d, actual %0d", want.src_offset, data[36:21]);
            errors++;
         end
         if (data[37] !== want.eop) begin
            $error("end_of_packet: expected %0d, actual %0d", want.eop, data[37]);
            errors++;
         end
         if (data[43:38] !== want.new_tail) begin
            $error("new_tail: expected %0d, actual %0d", want.new_tail, data[43:38]);
            errors++;
         end
         if (tlast !== want.is_last) begin
            $error("last: expected %0d, actual %0d", want.is_last, tlast);
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = OP_SUBMIT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   rsp_tlast;

   int req_idle_pct = 13;
   int rsp_idle_pct = 64;
   ring_scoreboard sb = new();

   tx_descriptor_ring_segmenter #(
      .RING_DEPTH    (RING_DEPTH),
      .SEGMENT_BYTES (SEGMENT_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_segment(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // presents one request item and waits for it to be taken
   task automatic send_item(input logic op, input logic [LEN_W-1:0] len,
                            input logic [IDX_W-1:0] done_idx);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, done_idx, len};
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_item(op, len, done_idx);
   endtask

   task automatic submit(input logic [LEN_W-1:0] len);
      send_item(OP_SUBMIT, len, IDX_W'($urandom_range(RING_DEPTH - 1)));
   endtask

   task automatic complete(input logic [IDX_W-1:0] idx);
      send_item(OP_COMPLETE, LEN_W'($urandom_range(65535)), idx);
   endtask

   // holds the request side until every expected item has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.segment_q.size() != 0)
         @(posedge clock);
   endtask

   // random mix: mostly completions of the oldest busy slots and short packets
   task automatic random_items(input int count);
      int pick;
      int busy;
      int seg_n;
      logic [IDX_W-1:0] oldest;
      for (int n = 0; n < count; n++) begin
         busy = 0;
         oldest = sb.producer;
         for (int k = RING_DEPTH - 1; k >= 0; k--) begin
            if (!sb.slot_free[IDX_W'((sb.producer + k) % RING_DEPTH)]) begin
               busy++;
               oldest = IDX_W'((sb.producer + k) % RING_DEPTH);
            end
         end
         pick = $urandom_range(99);
         if (busy > 0 && pick < ((busy > 40) ? 75 : 50)) begin
            if ($urandom_range(99) < 75)
               complete(oldest);
            else
               complete(IDX_W'($urandom_range(RING_DEPTH - 1)));
         end else begin
            pick = $urandom_range(99);
            seg_n = $urandom_range(1, 10);
            if (pick < 8)
               submit('0);
            else if (pick < 22)
               submit(LEN_W'(seg_n * SEGMENT_BYTES + $urandom_range(2) - 1));
            else if (pick < 70)
               submit(LEN_W'($urandom_range(1, 2 * SEGMENT_BYTES)));
            else if (pick < 92)
               submit(LEN_W'($urandom_range(2 * SEGMENT_BYTES + 1, 10 * SEGMENT_BYTES)));
            else
               submit(LEN_W'($urandom_range(10 * SEGMENT_BYTES + 1, 65535)));
         end
      end
   endtask

   // watchdog
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   // main sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty, segment boundaries, longest packet, full ring, wrap
      submit(16'd0);
      submit(16'd1);
      submit(LEN_W'(SEGMENT_BYTES));
      submit(LEN_W'(SEGMENT_BYTES + 1));
      submit(16'hFFFF);
      submit(16'hFFFF);
      submit(LEN_W'(16 * SEGMENT_BYTES));
      submit(16'd1);
      complete(6'd0);
      complete(6'd63);
      complete(6'd63);
      submit(16'd1);
      submit(LEN_W'(2 * SEGMENT_BYTES + 1));
      for (int k = 1; k < 8; k++)
         complete(IDX_W'(k));
      submit(LEN_W'(3 * SEGMENT_BYTES));
      random_items(RANDOM_ITEMS / 2);
      wait_drained();
      random_items(RANDOM_ITEMS - RANDOM_ITEMS / 2);
      wait_drained();

      // sender mostly idle, receiver mostly ready
      req_idle_pct = 64;
      rsp_idle_pct = 13;
      random_items(RANDOM_ITEMS);
      wait_drained();

      // no idling on either side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_items(RANDOM_ITEMS);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.segment_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> tx_descriptor_ring_segmenter.f
+incdir+hdl
hdl/txdrs_pkg.sv
hdl/txdrs_seg_unit.sv
hdl/tx_descriptor_ring_segmenter.sv
tb/tx_descriptor_ring_segmenter_tb.sv
